// ===== src/sipt_pkg.sv =====
// ----------------------------------------------------------------------------
// sipt_pkg
// Shared types for the segment intersection point block: status codes, the
// input and result words, and the control bits that travel down the divider.
// ----------------------------------------------------------------------------
package sipt_pkg;

    // Result classification codes.
    typedef enum logic [1:0] {
        ST_CROSS     = 2'd0,
        ST_PARALLEL  = 2'd1,
        ST_COLLINEAR = 2'd2,
        ST_OUTSIDE   = 2'd3
    } t_status;

    // One input word: two segments as signed integer end points.
    typedef struct packed {
        logic signed [15:0] seg1_start_x;
        logic signed [15:0] seg1_start_y;
        logic signed [15:0] seg1_end_x;
        logic signed [15:0] seg1_end_y;
        logic signed [15:0] seg2_start_x;
        logic signed [15:0] seg2_start_y;
        logic signed [15:0] seg2_end_x;
        logic signed [15:0] seg2_end_y;
    } t_seg_in;

    // One result word.
    typedef struct packed {
        t_status            status;
        logic               intersects;
        logic signed [31:0] cross_x;
        logic signed [31:0] cross_y;
    } t_seg_out;

    // Control bits that ride alongside the divider lanes.
    typedef struct packed {
        t_status status;
        logic    hit;
        logic    neg_x;
        logic    neg_y;
    } t_cell_ctrl;

endpackage

// ===== src/sipt_div_cell.sv =====
// ----------------------------------------------------------------------------
// sipt_div_cell
// One restoring division step for the x and y lanes. Each cell holds one
// word of the divider pipeline and passes it to its neighbor when the neighbor can take it.
// ----------------------------------------------------------------------------
module sipt_div_cell #(
    parameter int DW = 34,
    parameter int QB = 33,
    parameter int CB = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_en_dn,
    output logic                  o_en_up,
    input  sipt_pkg::t_cell_ctrl  i_ctrl,
    input  logic [DW-1:0]         i_w,
    input  logic signed [CB-1:0]  i_base_x,
    input  logic signed [CB-1:0]  i_base_y,
    input  logic [DW-1:0]         i_rem_x,
    input  logic [DW-1:0]         i_rem_y,
    input  logic [QB-1:0]         i_num_x,
    input  logic [QB-1:0]         i_num_y,
    output logic                  o_valid,
    output sipt_pkg::t_cell_ctrl  o_ctrl,
    output logic [DW-1:0]         o_w,
    output logic signed [CB-1:0]  o_base_x,
    output logic signed [CB-1:0]  o_base_y,
    output logic [DW-1:0]         o_rem_x,
    output logic [DW-1:0]         o_rem_y,
    output logic [QB-1:0]         o_num_x,
    output logic [QB-1:0]         o_num_y
);
    import sipt_pkg::*;

    logic              r_valid;
    t_cell_ctrl        r_ctrl;
    logic [DW-1:0]     r_w;
    logic signed [CB-1:0] r_base_x, r_base_y;
    logic [DW-1:0]     r_rem_x, r_rem_y;
    logic [QB-1:0]     r_num_x, r_num_y;
    logic [DW-1:0]     n_rem_x, n_rem_y;
    logic [QB-1:0]     n_num_x, n_num_y;
    logic [DW:0]       t_x, t_y, d_x, d_y;
    logic              ge_x, ge_y;
    logic              load;

    // The cell takes a new word when empty or when its own word moves on.
    assign load    = !r_valid || i_en_dn;
    assign o_en_up = load;

    // Shift in the next numerator bit and subtract the divisor if it fits.
    always_comb begin
        t_x  = {i_rem_x, i_num_x[QB-1]};
        t_y  = {i_rem_y, i_num_y[QB-1]};
        ge_x = t_x >= {1'b0, i_w};
        ge_y = t_y >= {1'b0, i_w};
        d_x  = t_x - {1'b0, i_w};
        d_y  = t_y - {1'b0, i_w};
        n_rem_x = ge_x ? d_x[DW-1:0] : t_x[DW-1:0];
        n_rem_y = ge_y ? d_y[DW-1:0] : t_y[DW-1:0];
        n_num_x = {i_num_x[QB-2:0], ge_x};
        n_num_y = {i_num_y[QB-2:0], ge_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ctrl   <= i_ctrl;
            r_w      <= i_w;
            r_base_x <= i_base_x;
            r_base_y <= i_base_y;
            r_rem_x  <= n_rem_x;
            r_rem_y  <= n_rem_y;
            r_num_x  <= n_num_x;
            r_num_y  <= n_num_y;
        end
    end

    assign o_valid  = r_valid;
    assign o_ctrl   = r_ctrl;
    assign o_w      = r_w;
    assign o_base_x = r_base_x;
    assign o_base_y = r_base_y;
    assign o_rem_x  = r_rem_x;
    assign o_rem_y  = r_rem_y;
    assign o_num_x  = r_num_x;
    assign o_num_y  = r_num_y;

endmodule

// ===== src/segment_intersection_point_top.sv =====
// Throughput: one word per cycle while the output is not stalled;
// the divider is a chain of one-bit cells, one per quotient bit.
// Bubbles close up, so words are accepted while a finished result waits to be taken.
// Reset (synchronous, active low) empties all stages and clears the tolerance register to zero.
// ----------------------------------------------------------------------------
// segment_intersection_point_top
// Cramer determinants, collinear/parallel/range classification and a
// pipelined divider giving the crossing point in signed fixed point.
// ----------------------------------------------------------------------------
module segment_intersection_point_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sipt_pkg::t_seg_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sipt_pkg::t_seg_out o_out_data,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);
    import sipt_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int D  = C + 1;
    localparam int PR = 2 * C + 2;
    localparam int SW = 2 * C + 3;
    localparam int DW = 2 * C + 2;
    localparam int PW = DW + D;
    localparam int QB = C + F + 1;
    localparam int VW = C + F + 4;

    // Tolerance register.
    logic [15:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Stage valids and load enables.
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic en1, en2, en3, en4, en_out;
    logic en_c [0:QB];

    assign en_out   = !r_out_valid || !i_out_stall;
    assign en4      = !r_v4 || en_c[0];
    assign en3      = !r_v3 || en4;
    assign en2      = !r_v2 || en3;
    assign en1      = !r_v1 || en2;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Coordinate extraction: low bits of each field, zero-extended when wider.
    function automatic logic signed [C-1:0] coord(input logic [15:0] f);
        logic [31:0] z;
        z = {16'b0, f};
        return z[C-1:0];
    endfunction

    logic signed [C-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    assign x1 = coord(i_in_data.seg1_start_x);
    assign y1 = coord(i_in_data.seg1_start_y);
    assign x2 = coord(i_in_data.seg1_end_x);
    assign y2 = coord(i_in_data.seg1_end_y);
    assign x3 = coord(i_in_data.seg2_start_x);
    assign y3 = coord(i_in_data.seg2_start_y);
    assign x4 = coord(i_in_data.seg2_end_x);
    assign y4 = coord(i_in_data.seg2_end_y);

    // Stage 1: coordinate differences.
    logic signed [D-1:0] r1_dx, r1_dy, r1_a, r1_b, r1_c, r1_e;
    logic signed [C-1:0] r1_x1, r1_y1;
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_dx <= D'(x2) - D'(x1);
            r1_dy <= D'(y2) - D'(y1);
            r1_a  <= D'(y3) - D'(y4);
            r1_b  <= D'(x4) - D'(x3);
            r1_c  <= D'(x3) - D'(x1);
            r1_e  <= D'(y3) - D'(y1);
            r1_x1 <= x1;
            r1_y1 <= y1;
        end
    end

    // Stage 2: the six determinant products.
    logic signed [PR-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [D-1:0]  r2_dx, r2_dy;
    logic signed [C-1:0]  r2_x1, r2_y1;
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_p0 <= r1_dx * r1_a;
            r2_p1 <= r1_b * r1_dy;
            r2_p2 <= r1_c * r1_a;
            r2_p3 <= r1_b * r1_e;
            r2_p4 <= r1_dx * r1_e;
            r2_p5 <= r1_c * r1_dy;
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_x1 <= r1_x1;
            r2_y1 <= r1_y1;
        end
    end

    // Stage 3: determinants, magnitudes and classification.
    logic signed [SW-1:0] w, ws, wt, nw, nws, nwt;
    logic [DW-1:0]        w_mag, ws_mag, wt_mag, tol_ext;
    logic                 wz, in_s, in_t;
    t_status              cls;
    always_comb begin
        w   = SW'(r2_p0) + SW'(r2_p1);
        ws  = SW'(r2_p2) + SW'(r2_p3);
        wt  = SW'(r2_p4) - SW'(r2_p5);
        nw  = -w;
        nws = -ws;
        nwt = -wt;
        w_mag  = w[SW-1]  ? nw[DW-1:0]  : w[DW-1:0];
        ws_mag = ws[SW-1] ? nws[DW-1:0] : ws[DW-1:0];
        wt_mag = wt[SW-1] ? nwt[DW-1:0] : wt[DW-1:0];
        tol_ext = DW'(r_tol);
        wz = w_mag <= tol_ext;
        if (w > 0) begin
            in_s = (ws >= 0) && (ws <= w);
            in_t = (wt >= 0) && (wt <= w);
        end else begin
            in_s = (ws <= 0) && (ws >= w);
            in_t = (wt <= 0) && (wt >= w);
        end
        if (wz && (ws_mag <= tol_ext) && (wt_mag <= tol_ext)) begin
            cls = ST_COLLINEAR;
        end else if (wz) begin
            cls = ST_PARALLEL;
        end else if (!in_s || !in_t) begin
            cls = ST_OUTSIDE;
        end else begin
            cls = ST_CROSS;
        end
    end

    t_cell_ctrl          r3_ctrl;
    logic [DW-1:0]       r3_w, r3_ws;
    logic [D-1:0]        r3_adx, r3_ady;
    logic signed [C-1:0] r3_x1, r3_y1;
    logic signed [D-1:0] ndx, ndy;
    assign ndx = -r2_dx;
    assign ndy = -r2_dy;
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_ctrl.status <= cls;
            r3_ctrl.hit    <= (cls == ST_CROSS) || (cls == ST_COLLINEAR);
            r3_ctrl.neg_x  <= r2_dx[D-1];
            r3_ctrl.neg_y  <= r2_dy[D-1];
            r3_w   <= w_mag;
            r3_ws  <= ws_mag;
            r3_adx <= r2_dx[D-1] ? ndx : r2_dx;
            r3_ady <= r2_dy[D-1] ? ndy : r2_dy;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
        end
    end

    // Stage 4: dividend products and initial remainder for the divider.
    logic [PW-1:0] px, py;
    assign px = PW'(r3_ws) * PW'(r3_adx);
    assign py = PW'(r3_ws) * PW'(r3_ady);

    t_cell_ctrl          r4_ctrl;
    logic [DW-1:0]       r4_w, r4_rem_x, r4_rem_y;
    logic [QB-1:0]       r4_num_x, r4_num_y;
    logic signed [C-1:0] r4_x1, r4_y1;
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_ctrl  <= r3_ctrl;
            r4_w     <= r3_w;
            r4_rem_x <= px[PW-1:D];
            r4_rem_y <= py[PW-1:D];
            r4_num_x <= {px[D-1:0], {F{1'b0}}};
            r4_num_y <= {py[D-1:0], {F{1'b0}}};
            r4_x1    <= r3_x1;
            r4_y1    <= r3_y1;
        end
    end

    // Divider chain: one quotient bit per cell.
    logic                c_valid  [0:QB];
    t_cell_ctrl          c_ctrl   [0:QB];
    logic [DW-1:0]       c_w      [0:QB];
    logic signed [C-1:0] c_base_x [0:QB];
    logic signed [C-1:0] c_base_y [0:QB];
    logic [DW-1:0]       c_rem_x  [0:QB];
    logic [DW-1:0]       c_rem_y  [0:QB];
    logic [QB-1:0]       c_num_x  [0:QB];
    logic [QB-1:0]       c_num_y  [0:QB];

    assign c_valid[0]  = r_v4;
    assign c_ctrl[0]   = r4_ctrl;
    assign c_w[0]      = r4_w;
    assign c_base_x[0] = r4_x1;
    assign c_base_y[0] = r4_y1;
    assign c_rem_x[0]  = r4_rem_x;
    assign c_rem_y[0]  = r4_rem_y;
    assign c_num_x[0]  = r4_num_x;
    assign c_num_y[0]  = r4_num_y;
    assign en_c[QB]    = en_out;

    for (genvar k = 0; k < QB; k++) begin : g_cell
        sipt_div_cell #(
            .DW(DW),
            .QB(QB),
            .CB(C)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (c_valid[k]),
            .i_en_dn  (en_c[k+1]),
            .o_en_up  (en_c[k]),
            .i_ctrl   (c_ctrl[k]),
            .i_w      (c_w[k]),
            .i_base_x (c_base_x[k]),
            .i_base_y (c_base_y[k]),
            .i_rem_x  (c_rem_x[k]),
            .i_rem_y  (c_rem_y[k]),
            .i_num_x  (c_num_x[k]),
            .i_num_y  (c_num_y[k]),
            .o_valid  (c_valid[k+1]),
            .o_ctrl   (c_ctrl[k+1]),
            .o_w      (c_w[k+1]),
            .o_base_x (c_base_x[k+1]),
            .o_base_y (c_base_y[k+1]),
            .o_rem_x  (c_rem_x[k+1]),
            .o_rem_y  (c_rem_y[k+1]),
            .o_num_x  (c_num_x[k+1]),
            .o_num_y  (c_num_y[k+1])
        );
    end

    // Round to nearest, apply sign, add the base point and saturate.
    function automatic logic signed [31:0] finish(
        input logic signed [C-1:0] base,
        input logic                neg,
        input logic [QB-1:0]       q,
        input logic [DW-1:0]       rem,
        input logic [DW-1:0]       wm
    );
        logic [VW-1:0]        off;
        logic signed [VW-1:0] bsh, v;
        logic signed [63:0]   v64;
        off = VW'(q) + VW'({rem, 1'b0} >= {1'b0, wm});
        bsh = VW'(base) <<< F;
        v   = neg ? bsh - $signed(off) : bsh + $signed(off);
        v64 = {{(64 - VW){v[VW-1]}}, v};
        if (v64 > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v64 < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v64[31:0];
    endfunction

    // Output register.
    t_seg_out r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= c_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out.status     <= c_ctrl[QB].status;
            r_out.intersects <= c_ctrl[QB].hit;
            if (c_ctrl[QB].status == ST_CROSS) begin
                r_out.cross_x <= finish(c_base_x[QB], c_ctrl[QB].neg_x, c_num_x[QB],
                                        c_rem_x[QB], c_w[QB]);
                r_out.cross_y <= finish(c_base_y[QB], c_ctrl[QB].neg_y, c_num_y[QB],
                                        c_rem_y[QB], c_w[QB]);
            end else begin
                r_out.cross_x <= '0;
                r_out.cross_y <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/sv/tb_segment_intersection_point_top.sv =====
// ----------------------------------------------------------------------------
// Segment intersection point testbench
// Drives segment pairs through the block under random idling and stalls,
// predicts status and crossing point for each accepted word, and checks
// every result word in order. The tolerance register is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_segment_intersection_point_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sipt_pkg::*;

    localparam int LATENCY     = 38;
    localparam int CYCLE_LIMIT = 400000;

    // Predicts result words from accepted segment pairs and checks the block.
    class crossing_board;
        t_seg_out pending_q[$];
        logic [15:0] tolerance;
        int mismatches;

        function new();
            tolerance = 16'd0;
            mismatches = 0;
        endfunction

        function automatic logic [63:0] abs64(logic signed [63:0] v);
            return v < 0 ? -v : v;
        endfunction

        function automatic bit in_unit(logic signed [63:0] num, logic signed [63:0] den);
            if (den > 0) return num >= 0 && num <= den;
            return num <= 0 && num >= den;
        endfunction

        // Exact rounded offset: |delta| * 2^16 * |ws| / |w|, halves away from zero.
        function automatic logic signed [31:0] locate(logic signed [63:0] base,
                logic signed [63:0] delta, logic [63:0] ws_mag, logic [63:0] w_mag);
            logic [127:0] prod;
            logic [127:0] quo;
            logic [127:0] rem;
            logic signed [127:0] v;
            prod = (abs64(delta) << 16) * ws_mag;
            quo = prod / w_mag;
            rem = prod % w_mag;
            if (rem >= w_mag - rem) quo++;
            v = (base <<< 16) + (delta < 0 ? -$signed(quo) : $signed(quo));
            if (v > 128'sd2147483647) v = 128'sd2147483647;
            if (v < -128'sd2147483648) v = -128'sd2147483648;
            return v[31:0];
        endfunction

        function void note_word(t_seg_in d);
            logic signed [63:0] x1, y1, x2, y2, x3, y3, x4, y4, w, ws, wt;
            t_seg_out r;
            bit wz;
            x1 = d.seg1_start_x; y1 = d.seg1_start_y;
            x2 = d.seg1_end_x;   y2 = d.seg1_end_y;
            x3 = d.seg2_start_x; y3 = d.seg2_start_y;
            x4 = d.seg2_end_x;   y4 = d.seg2_end_y;
            w  = (x2 - x1) * (y3 - y4) + (x4 - x3) * (y2 - y1);
            ws = (x3 - x1) * (y3 - y4) + (x4 - x3) * (y3 - y1);
            wt = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
            wz = abs64(w) <= tolerance;
            r = '0;
            if (wz && abs64(ws) <= tolerance && abs64(wt) <= tolerance) begin
                r.status = ST_COLLINEAR;
                r.intersects = 1'b1;
            end else if (wz) begin
                r.status = ST_PARALLEL;
            end else if (!in_unit(ws, w) || !in_unit(wt, w)) begin
                r.status = ST_OUTSIDE;
            end else begin
                r.status = ST_CROSS;
                r.intersects = 1'b1;
                r.cross_x = locate(x1, x2 - x1, abs64(ws), abs64(w));
                r.cross_y = locate(y1, y2 - y1, abs64(ws), abs64(w));
            end
            pending_q.push_back(r);
        endfunction

        function void check_word(t_seg_out got);
            t_seg_out exp_r;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.status !== exp_r.status || got.intersects !== exp_r.intersects ||
                    got.cross_x !== exp_r.cross_x || got.cross_y !== exp_r.cross_y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected st=%0d hit=%0d x=%0d y=%0d,",
                              " got st=%0d hit=%0d x=%0d y=%0d"},
                        exp_r.status, exp_r.intersects, exp_r.cross_x, exp_r.cross_y,
                        got.status, got.intersects, got.cross_x, got.cross_y);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, o_out_valid, i_out_stall, i_cfg_we;
    t_seg_in i_in_data;
    t_seg_out o_out_data;
    logic [15:0] i_cfg_wdata;
    crossing_board board = new();
    int hold_req = 0;
    int hold_done = 0;
    int cycles = 0;

    segment_intersection_point_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Note accepted input words and check accepted result words at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_word(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_word(o_out_data);
    end

    // Receiver: random stalls per word, plus one long hold on request.
    initial begin
        int gap;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_req) begin
                i_out_stall = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_done++;
                i_out_stall = 1'b0;
            end else if (o_out_valid && !i_out_stall) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 1)) gap = 0;
                i_out_stall = gap != 0;
                if (gap != 0) begin
                    repeat (gap - 1) @(negedge i_clk);
                    i_out_stall = 1'b0;
                end
            end
        end
    end

    // Hand one word to the block, after a random gap when idle_ok is set, and wait until accepted.
    task automatic send_word(t_seg_in d, bit idle_ok);
        int gap;
        gap = idle_ok ? $urandom_range(0, 17) : 0;
        if (idle_ok && $urandom_range(0, 1)) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_in_data = d;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic set_tolerance(logic [15:0] v);
        i_cfg_wdata = v;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.tolerance = v;
    endtask

    function automatic logic [15:0] rand_coord(int span);
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    // Two segments that usually cross: a point on each side of a center.
    function automatic t_seg_in crossing_pair(int span);
        t_seg_in d;
        int cx, cy;
        cx = $urandom_range(0, 2000) - 1000;
        cy = $urandom_range(0, 2000) - 1000;
        d.seg1_start_x = 16'(cx - $urandom_range(0, span));
        d.seg1_start_y = 16'(cy - $urandom_range(0, span) + span / 2);
        d.seg1_end_x   = 16'(cx + $urandom_range(0, span));
        d.seg1_end_y   = 16'(cy + $urandom_range(0, span) - span / 2);
        d.seg2_start_x = 16'(cx - $urandom_range(0, span) + span / 2);
        d.seg2_start_y = 16'(cy + $urandom_range(0, span));
        d.seg2_end_x   = 16'(cx + $urandom_range(0, span) - span / 2);
        d.seg2_end_y   = 16'(cy - $urandom_range(0, span));
        return d;
    endfunction

    function automatic t_seg_in random_pair();
        t_seg_in d;
        int span;
        span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 300);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: d = crossing_pair(span);
            5: begin
                // Parallel segments: second is the first shifted.
                d = crossing_pair(span);
                d.seg2_end_x = d.seg2_start_x + (d.seg1_end_x - d.seg1_start_x);
                d.seg2_end_y = d.seg2_start_y + (d.seg1_end_y - d.seg1_start_y);
            end
            6: begin
                // Collinear segments on one line.
                d = crossing_pair(100);
                d.seg2_start_x = 16'(d.seg1_start_x + 2 * (d.seg1_end_x - d.seg1_start_x));
                d.seg2_start_y = 16'(d.seg1_start_y + 2 * (d.seg1_end_y - d.seg1_start_y));
                d.seg2_end_x = d.seg1_start_x - (d.seg1_end_x - d.seg1_start_x);
                d.seg2_end_y = d.seg1_start_y - (d.seg1_end_y - d.seg1_start_y);
            end
            default: begin
                d.seg1_start_x = rand_coord(span); d.seg1_start_y = rand_coord(span);
                d.seg1_end_x = rand_coord(span);   d.seg1_end_y = rand_coord(span);
                d.seg2_start_x = rand_coord(span); d.seg2_start_y = rand_coord(span);
                d.seg2_end_x = rand_coord(span);   d.seg2_end_y = rand_coord(span);
            end
        endcase
        return d;
    endfunction

    function automatic t_seg_in make_pair(int a, int b, int c, int e, int f, int g, int h, int k);
        t_seg_in d;
        d.seg1_start_x = 16'(a); d.seg1_start_y = 16'(b);
        d.seg1_end_x   = 16'(c); d.seg1_end_y   = 16'(e);
        d.seg2_start_x = 16'(f); d.seg2_start_y = 16'(g);
        d.seg2_end_x   = 16'(h); d.seg2_end_y   = 16'(k);
        return d;
    endfunction

    // Watchdog on the cycle count.
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Main sequence.
    initial begin
        logic [15:0] tol_set[6];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 16'd0;
        tol_set = '{16'd0, 16'd65535, 16'd1, 16'd500, 16'd3, 16'd0};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed words at reset tolerance.
        send_word(make_pair(0, 0, 4, 4, 0, 4, 4, 0), 1'b0);
        send_word(make_pair(0, 0, 1, 0, 1, 0, 1, 5), 1'b0);
        send_word(make_pair(0, 0, 4, 0, 0, 1, 4, 1), 1'b0);
        send_word(make_pair(0, 0, 4, 4, 1, 1, 9, 9), 1'b0);
        send_word(make_pair(0, 0, 1, 1, 5, 0, 6, -1), 1'b0);
        send_word(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_word(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1'b0);
        send_word(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), 1'b0);
        send_word(make_pair(0, 0, 3, 1, 0, 1, 3, 0), 1'b0);
        send_word(make_pair(0, 0, -3, -1, 0, -1, -3, 0), 1'b0);
        send_word(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1'b0);
        send_word(make_pair(0, 0, 7, 3, 7, 0, 0, 3), 1'b0);
        send_word(make_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
        drain();
        set_tolerance(16'd65535);
        send_word(make_pair(0, 0, 4, 4, 0, 4, 4, 0), 1'b0);
        send_word(make_pair(0, 0, 1, 0, 0, 1, 1, 1), 1'b0);
        drain();

        // Random phases over a spread of tolerances.
        for (int p = 0; p < 6; p++) begin
            set_tolerance(tol_set[p]);
            for (int n = 0; n < 215; n++) begin
                if (p == 2 && n == 50) hold_req++;
                send_word(random_pair(), (p == 2 && n >= 50 && n < 150) ? 1'b0 : 1'b1);
                if (p == 3 && n == 100) drain();
            end
            drain();
        end

        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/sipt_pkg.sv
src/sipt_div_cell.sv
src/segment_intersection_point_top.sv
tb/sv/tb_segment_intersection_point_top.sv
